// ----- hw/rtl/t3ttr_pkg.sv -----
// Shared widths, record layout and result codes of the T3 record decoder.
package t3ttr_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned NSYNC_W    = 16;
	localparam int unsigned MID_W      = 12;
	localparam int unsigned CHAN_W     = 4;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned OVF_W      = 32;
	localparam int unsigned TSYNC_W    = 48;
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned PERIOD_W   = 32;
	localparam int unsigned RES_W      = 16;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CHAN_W-1:0] SPECIAL_CHANNEL   = 4'hF;
	localparam logic [CHAN_W-1:0] LAST_LEGAL_CHANNEL = 4'd4;

	localparam logic [KIND_W-1:0] KIND_PHOTON   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MARKER   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ILLEGAL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PERIOD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION  = 4'd1;

	localparam logic [PERIOD_W-1:0] SYNC_PERIOD_RESET = 32'd10000;
	localparam logic [RES_W-1:0]    RESOLUTION_RESET  = 16'd4;

	// Fields that ride unchanged down the pipeline alongside the arithmetic.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CHAN_W-1:0]  channel;
		logic [MID_W-1:0]   marker_bits;
		logic [MID_W-1:0]   start_stop_bin;
		logic [TSYNC_W-1:0] true_sync;
	} rec_meta_t;

endpackage

// ----- hw/rtl/t3_time_tag_record_decoder_top.sv -----
// T3 time-tagged record decoder: classifies records, unwraps syncs, forms picosecond times.
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  record   | in_valid, in_ready, record_word                | in
//  result   | out_valid, out_ready, kind, channel,           | out
//           | marker_bits, start_stop_bin, true_sync,        |
//           | true_time_ps                                   |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// One record beat is taken per cycle while out_ready lets the pipeline advance;
// each result leaves through four registers. The depth is set by the 48 x 32
// sync-period product, split into a 32 x 32 and a 16 x 32 partial product and
// two registered adds.
// Reset sets the sync period to 10000 ps, the bin width to 4 ps and clears the
// overflow count and all stage valids. Each stage advances when it is empty or
// its successor advances, so bubbles close up while a result beat is stalled.
// Configuration beats are always taken.
module t3_time_tag_record_decoder_top
	import t3ttr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [WORD_W-1:0]     record_word,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [CHAN_W-1:0]     channel,
	output logic [MID_W-1:0]      marker_bits,
	output logic [MID_W-1:0]      start_stop_bin,
	output logic [TSYNC_W-1:0]    true_sync,
	output logic [TIME_W-1:0]     true_time_ps,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers and running overflow count
	logic [PERIOD_W-1:0] sync_period_q;
	logic [RES_W-1:0]    resolution_q;
	logic [OVF_W-1:0]    overflow_count_q;

	// Stage valids and handshake chain
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;
	logic in_fire;

	// Record decode
	logic [NSYNC_W-1:0] rec_nsync;
	logic [MID_W-1:0]   rec_mid;
	logic [CHAN_W-1:0]  rec_chan;
	logic               rec_special;
	logic               rec_overflow;
	rec_meta_t          rec_meta;

	// Pipeline payload
	rec_meta_t             meta_s1, meta_s2, meta_s3, meta_s4;
	logic [TSYNC_W-1:0]    hi_prod_s2, hi_prod_s3;
	logic [TSYNC_W-1:0]    lo_prod_s2;
	logic [MID_W+RES_W-1:0] bin_prod_s2;
	logic [TSYNC_W:0]      low_sum_s3;
	logic [TIME_W-1:0]     time_s4;

	assign adv4     = !valid_s4 || out_ready;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;
	assign in_fire  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Split the record and classify it
	assign rec_nsync    = record_word[NSYNC_W-1:0];
	assign rec_mid      = record_word[NSYNC_W+MID_W-1:NSYNC_W];
	assign rec_chan     = record_word[WORD_W-1:NSYNC_W+MID_W];
	assign rec_special  = (rec_chan == SPECIAL_CHANNEL);
	assign rec_overflow = rec_special && (rec_mid == '0);

	always_comb begin
		rec_meta.channel        = rec_chan;
		rec_meta.marker_bits    = '0;
		rec_meta.start_stop_bin = '0;
		rec_meta.true_sync      = {overflow_count_q, rec_nsync};
		priority if (rec_overflow) begin
			// An overflow carries no time: zero the sync so the products vanish
			rec_meta.kind      = KIND_OVERFLOW;
			rec_meta.true_sync = '0;
		end else if (rec_special) begin
			rec_meta.kind        = KIND_MARKER;
			rec_meta.marker_bits = rec_mid;
		end else begin
			rec_meta.start_stop_bin = rec_mid;
			if (rec_chan == '0 || rec_chan > LAST_LEGAL_CHANNEL) begin
				rec_meta.kind = KIND_ILLEGAL;
			end else begin
				rec_meta.kind = KIND_PHOTON;
			end
		end
	end

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_period_q <= SYNC_PERIOD_RESET;
			resolution_q  <= RESOLUTION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SYNC_PERIOD) begin
				sync_period_q <= cfg_data[PERIOD_W-1:0];
			end else if (cfg_index == REG_RESOLUTION) begin
				resolution_q <= cfg_data[RES_W-1:0];
			end
		end
	end

	// Advance the overflow count when an overflow beat is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_count_q <= '0;
		end else if (in_fire && rec_overflow) begin
			overflow_count_q <= overflow_count_q + 1'b1;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: hold the decoded record with the count it saw
	always_ff @(posedge clk) begin
		if (in_fire) begin
			meta_s1 <= rec_meta;
		end
	end

	// Stage 2: partial products of sync x period, and bin x resolution.
	// The high product is shifted left by 16 later, so its top 16 bits fall off.
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			meta_s2     <= meta_s1;
			hi_prod_s2  <= TSYNC_W'(meta_s1.true_sync[TSYNC_W-1:NSYNC_W] * sync_period_q);
			lo_prod_s2  <= TSYNC_W'(meta_s1.true_sync[NSYNC_W-1:0] * sync_period_q);
			bin_prod_s2 <= meta_s1.start_stop_bin * resolution_q;
		end
	end

	// Stage 3: fold the two narrow products together
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			meta_s3    <= meta_s2;
			hi_prod_s3 <= hi_prod_s2;
			low_sum_s3 <= {1'b0, lo_prod_s2}
				+ {{(TSYNC_W+1-MID_W-RES_W){1'b0}}, bin_prod_s2};
		end
	end

	// Stage 4: result register, time wraps modulo 2^64
	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			meta_s4 <= meta_s3;
			time_s4 <= {hi_prod_s3, {NSYNC_W{1'b0}}}
				+ {{(TIME_W-TSYNC_W-1){1'b0}}, low_sum_s3};
		end
	end

	assign out_valid      = valid_s4;
	assign kind           = meta_s4.kind;
	assign channel        = meta_s4.channel;
	assign marker_bits    = meta_s4.marker_bits;
	assign start_stop_bin = meta_s4.start_stop_bin;
	assign true_sync      = meta_s4.true_sync;
	assign true_time_ps   = time_s4;

endmodule
